>>> rtl/pseg_pkg.sv
// ----------------------------------------------------------------------------
// pseg_pkg
// Shared types and constants of the packet segmenter: the work descriptor
// that the front hands to the back, and the segment size limits.
// ----------------------------------------------------------------------------
package pseg_pkg;

  localparam logic [15:0] SEG_SIZE_RESET = 16'd1024;
  localparam logic [15:0] SEG_SIZE_MIN   = 16'd1;
  localparam logic [15:0] SEG_SIZE_MAX   = 16'd65534;
  localparam logic [15:0] SEG_SIZE_ALL1  = 16'hFFFF;

  // One accepted byte turned into the output bytes it causes.
  typedef struct packed {
    logic        hdr;       // emit the six header bytes first
    logic [15:0] hlen;      // header length field
    logic [15:0] pid;       // packet number
    logic [15:0] idx;       // subpacket index, bit 15 marks the last one
    logic [7:0]  data;      // the data byte itself
    logic        data_end;  // data byte closes its subpacket
    logic        pend;      // data byte closes the whole packet
    logic        cmd_en;    // append the command byte after the data byte
    logic [7:0]  cmd;       // command byte
  } pseg_job_t;

endpackage

>>> rtl/pseg_if.sv
// ----------------------------------------------------------------------------
// pseg_if
// Valid/ready channels of the packet segmenter: byte input, result output
// and the segment size write port.
// ----------------------------------------------------------------------------
interface pseg_in_if #(
  parameter int LENGTH_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic                   start_of_packet;
  logic [LENGTH_BITS-1:0] packet_length;
  logic [7:0]             command_byte;

  modport source (output valid, data_byte, start_of_packet, packet_length, command_byte,
                  input ready);
  modport sink (input valid, data_byte, start_of_packet, packet_length, command_byte,
                output ready);
endinterface

interface pseg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       subpacket_first;
  logic       subpacket_end;
  logic       packet_end;
  logic       last;

  modport source (output valid, out_byte, subpacket_first, subpacket_end, packet_end, last,
                  input ready);
  modport sink (input valid, out_byte, subpacket_first, subpacket_end, packet_end, last,
                output ready);
endinterface

interface pseg_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] segment_size;

  modport source (output valid, segment_size, input ready);
  modport sink (input valid, segment_size, output ready);
endinterface

>>> rtl/pseg_front.sv
// ----------------------------------------------------------------------------
// pseg_front
// Accepts input bytes, tracks the split state and turns each byte that
// produces output into one work descriptor for the queue.
// ----------------------------------------------------------------------------
module pseg_front #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  pseg_in_if.sink               packet,
  pseg_cfg_if.sink              cfg,
  input  logic                  q_full,
  output logic                  q_push,
  output pseg_pkg::pseg_job_t   q_job
);

  logic [15:0]            seg_size;
  logic [15:0]            pkt_counter;
  logic [15:0]            pkt_counter_next;
  logic [15:0]            cur_id;
  logic [15:0]            cur_id_next;
  logic [14:0]            sub_idx;
  logic [14:0]            sub_idx_next;
  logic [15:0]            seg_bytes;
  logic [15:0]            seg_bytes_next;
  logic [LENGTH_BITS-1:0] remain;
  logic [LENGTH_BITS-1:0] remain_next;
  logic [7:0]             cmd_reg;
  logic [7:0]             cmd_reg_next;
  logic                   active;
  logic                   active_next;

  logic [15:0]            seg_eff;
  logic [LENGTH_BITS-1:0] seg_wide;
  logic                   act_c;
  logic [15:0]            bis_c;
  logic [LENGTH_BITS-1:0] brem_c;
  logic [14:0]            sidx_c;
  logic                   hdr;
  logic                   is_last;
  logic [15:0]            dlen;
  logic [15:0]            bis_h;
  logic [15:0]            bis_n;
  logic [LENGTH_BITS-1:0] brem_n;
  logic                   first_end;
  logic                   other_end;
  logic                   done;
  logic                   accept;

  assign cfg.ready    = 1'b1;
  assign packet.ready = !q_full;
  assign accept       = packet.valid && packet.ready;

  always_comb begin
    if (seg_size == 16'd0) begin
      seg_eff = pseg_pkg::SEG_SIZE_MIN;
    end else if (seg_size == pseg_pkg::SEG_SIZE_ALL1) begin
      seg_eff = pseg_pkg::SEG_SIZE_MAX;
    end else begin
      seg_eff = seg_size;
    end
    seg_wide = LENGTH_BITS'(seg_eff);
  end

  always_comb begin
    act_c            = active;
    bis_c            = seg_bytes;
    brem_c           = remain;
    sidx_c           = sub_idx;
    cur_id_next      = cur_id;
    cmd_reg_next     = cmd_reg;
    pkt_counter_next = pkt_counter;
    // a start abandons any split in progress
    if (packet.start_of_packet) begin
      act_c = 1'b0;
      bis_c = 16'd0;
      if (packet.packet_length > seg_wide) begin
        act_c            = 1'b1;
        cmd_reg_next     = packet.command_byte;
        cur_id_next      = pkt_counter;
        pkt_counter_next = pkt_counter + 16'd1;
        sidx_c           = 15'd0;
        brem_c           = packet.packet_length;
      end
    end

    hdr       = (bis_c == 16'd0);
    is_last   = (brem_c <= seg_wide);
    dlen      = is_last ? brem_c[15:0] : seg_eff;
    bis_h     = hdr ? dlen : bis_c;
    bis_n     = bis_h - 16'd1;
    brem_n    = brem_c - LENGTH_BITS'(1);
    done      = (brem_n == '0);
    first_end = (bis_n == 16'd0) && (sidx_c == 15'd0);
    other_end = (bis_n == 16'd0) && (sidx_c != 15'd0);

    if (act_c) begin
      active_next    = !((first_end || other_end) && done);
      seg_bytes_next = bis_n;
      remain_next    = brem_n;
      if (first_end) begin
        sub_idx_next = 15'd1;
      end else if (other_end) begin
        sub_idx_next = sidx_c + 15'd1;
      end else begin
        sub_idx_next = sidx_c;
      end
    end else begin
      active_next    = 1'b0;
      seg_bytes_next = bis_c;
      remain_next    = brem_c;
      sub_idx_next   = sidx_c;
    end

    q_job.hdr      = hdr;
    q_job.hlen     = dlen + {15'd0, (sidx_c == 15'd0)};
    q_job.pid      = cur_id_next;
    q_job.idx      = {is_last, sidx_c};
    q_job.data     = packet.data_byte;
    q_job.data_end = other_end;
    q_job.pend     = other_end && done;
    q_job.cmd_en   = first_end;
    q_job.cmd      = cmd_reg_next;
  end

  assign q_push = accept && act_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_size    <= pseg_pkg::SEG_SIZE_RESET;
      pkt_counter <= 16'd0;
      cur_id      <= 16'd0;
      sub_idx     <= 15'd0;
      seg_bytes   <= 16'd0;
      remain      <= '0;
      cmd_reg     <= 8'd0;
      active      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        seg_size <= cfg.segment_size;
      end
      if (accept) begin
        pkt_counter <= pkt_counter_next;
        cur_id      <= cur_id_next;
        sub_idx     <= sub_idx_next;
        seg_bytes   <= seg_bytes_next;
        remain      <= remain_next;
        cmd_reg     <= cmd_reg_next;
        active      <= active_next;
      end
    end
  end

endmodule

>>> rtl/pseg_queue.sv
// ----------------------------------------------------------------------------
// pseg_queue
// Small first-in first-out buffer of work descriptors between front and back.
// ----------------------------------------------------------------------------
module pseg_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pseg_pkg::pseg_job_t push_job,
  output logic                full,
  input  logic                pop,
  output pseg_pkg::pseg_job_t head,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pseg_pkg::pseg_job_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not advance on write");

endmodule

>>> rtl/pseg_back.sv
// ----------------------------------------------------------------------------
// pseg_back
// Walks each work descriptor byte by byte: header, data, command, and drives
// the registered output channel.
// ----------------------------------------------------------------------------
module pseg_back (
  input  logic                clk,
  input  logic                rst,
  input  pseg_pkg::pseg_job_t head,
  input  logic                empty,
  output logic                pop,
  pseg_out_if.source          segment
);

  localparam logic [2:0] STEP_HLEN_LO = 3'd0;
  localparam logic [2:0] STEP_HLEN_HI = 3'd1;
  localparam logic [2:0] STEP_PID_LO  = 3'd2;
  localparam logic [2:0] STEP_PID_HI  = 3'd3;
  localparam logic [2:0] STEP_IDX_LO  = 3'd4;
  localparam logic [2:0] STEP_IDX_HI  = 3'd5;
  localparam logic [2:0] STEP_DATA    = 3'd6;
  localparam logic [2:0] STEP_CMD     = 3'd7;

  logic       mid;
  logic [2:0] step;
  logic [2:0] cur_step;
  logic [2:0] end_step;
  logic       emit;
  logic       job_done;
  logic       out_valid;
  logic [7:0] byte_c;
  logic       first_c;
  logic       send_c;
  logic       pend_c;

  assign cur_step = mid ? step : (head.hdr ? STEP_HLEN_LO : STEP_DATA);
  assign end_step = head.cmd_en ? STEP_CMD : STEP_DATA;
  assign job_done = (cur_step == end_step);
  assign emit     = !empty && (!out_valid || segment.ready);
  assign pop      = emit && job_done;

  always_comb begin
    first_c = 1'b0;
    send_c  = 1'b0;
    pend_c  = 1'b0;
    case (cur_step)
      STEP_HLEN_LO: begin
        byte_c  = head.hlen[7:0];
        first_c = 1'b1;
      end
      STEP_HLEN_HI: byte_c = head.hlen[15:8];
      STEP_PID_LO:  byte_c = head.pid[7:0];
      STEP_PID_HI:  byte_c = head.pid[15:8];
      STEP_IDX_LO:  byte_c = head.idx[7:0];
      STEP_IDX_HI:  byte_c = head.idx[15:8];
      STEP_DATA: begin
        byte_c = head.data;
        send_c = head.data_end;
        pend_c = head.pend;
      end
      STEP_CMD: begin
        byte_c = head.cmd;
        send_c = 1'b1;
      end
      default: byte_c = head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid       <= 1'b0;
      step      <= STEP_HLEN_LO;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        mid       <= !job_done;
        step      <= cur_step + 3'd1;
        out_valid <= 1'b1;
      end else if (segment.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      segment.out_byte        <= byte_c;
      segment.subpacket_first <= first_c;
      segment.subpacket_end   <= send_c;
      segment.packet_end      <= pend_c;
      segment.last            <= job_done;
    end
  end

  assign segment.valid = out_valid;

  a_mid_follows: assert property (@(posedge clk) disable iff (rst)
    (emit && !job_done) |=> mid)
    else $error("descriptor left before its last byte");
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    (segment.valid && segment.subpacket_first) |-> !segment.last)
    else $error("header start marked as final byte of an item");
  a_pend_marks: assert property (@(posedge clk) disable iff (rst)
    (segment.valid && segment.packet_end) |-> (segment.subpacket_end && segment.last))
    else $error("packet end without subpacket end");

endmodule

>>> rtl/packet_segmenter_unit.sv
// ----------------------------------------------------------------------------
// packet_segmenter_unit
// Splits long byte-stream packets into numbered subpackets with headers.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle whenever its descriptor queue has
// room, and sends one result byte per cycle on the output channel while the
// output is ready and a descriptor waits. An input byte yields 0, 1, 2, 7 or
// 8 result bytes; the output sequencer moves one byte per cycle under that
// same condition, header bytes first, then the data byte, then any command
// byte, and bytes that produce nothing are taken on the input side only.
// QUEUE_DEPTH descriptors decouple the two sides, so input keeps flowing
// through short output stalls and across header insertion until the queue is
// full. Bytes outside a split packet and packets no longer than the segment
// size are consumed silently. Write segment_size only while the block is idle;
// a value of 0 acts as 1 and 65535 acts as 65534. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module packet_segmenter_unit #(
  parameter int LENGTH_BITS = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  pseg_in_if.sink    packet,
  pseg_cfg_if.sink   cfg,
  pseg_out_if.source segment
);

  // front to queue
  logic                push;
  pseg_pkg::pseg_job_t push_job;
  logic                full;
  // queue to back
  logic                pop;
  pseg_pkg::pseg_job_t head;
  logic                empty;

  // Classify input bytes and track split state; push one descriptor per
  // byte that produces output.
  pseg_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .packet (packet),
    .cfg    (cfg),
    .q_full (full),
    .q_push (push),
    .q_job  (push_job)
  );

  // Hold descriptors so front and back stall independently.
  pseg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Expand each descriptor into header, data and command bytes.
  pseg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .segment (segment)
  );

endmodule
